@@ design/dstwr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared widths, codes and command/status types of the ranging engine.
// ----------------------------------------------------------------------------
package dstwr_pkg;
	localparam int STAMP_BITS = 40;
	localparam int PROD_BITS  = 2 * STAMP_BITS;
	localparam int DEN_BITS   = STAMP_BITS + 2;
	localparam int CNT_BITS   = $clog2(PROD_BITS + 1);
	localparam int TP_BITS    = 41;
	localparam int DIST_BITS  = 32;
	localparam logic [STAMP_BITS-1:0] ANSWER_DELAY_RST = STAMP_BITS'(64'd319488000);
	localparam logic [14:0] DIST_MUL = 15'd15625;
	// ceil(2^39 / 13): exact quotient by 13 for dividends below 2^35
	localparam logic [35:0] DIST_RECIP = 36'd42288908761;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_RX_OK = 2'd1;
	localparam logic [1:0] CMD_RX_ERR = 2'd2;
	localparam logic [1:0] CMD_TX_DONE = 2'd3;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_SEND_NOW = 3'd1;
	localparam logic [2:0] ACT_SEND_DLY = 3'd2;
	localparam logic [2:0] ACT_RANGE = 3'd3;
	localparam logic [2:0] ACT_RX_RESET = 3'd4;
	localparam logic [2:0] ACT_RX_START = 3'd5;

	typedef struct packed {
		logic simple;   // finish event in one step
		logic mul_a;    // form low half of Ra*Rb, denominator
		logic mul_a_hi; // add high half of Ra*Rb
		logic mul_b;    // form low half of Da*Db
		logic mul_b_hi; // add high half of Da*Db
		logic div_init;
		logic div_step;
		logic dist_mul;
		logic dist_lo;
		logic dist_hi;
		logic finish_range;
	} dstwr_cmd_t;

	typedef struct packed {
		logic is_range;
		logic div_done;
		logic den_zero;
	} dstwr_sts_t;
endpackage
`default_nettype wire

@@ design/dstwr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_ctrl
// Sequencer: accepts one transaction, steps the datapath, holds the result.
// ----------------------------------------------------------------------------
module dstwr_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire dstwr_pkg::dstwr_sts_t sts,
	output dstwr_pkg::dstwr_cmd_t      cmd
);
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_DEC   = 12'b000000000010,
		ST_MULA2 = 12'b000000000100,
		ST_MULB  = 12'b000000001000,
		ST_MULB2 = 12'b000000010000,
		ST_DINI  = 12'b000000100000,
		ST_DIV   = 12'b000001000000,
		ST_DMUL  = 12'b000010000000,
		ST_DLO   = 12'b000100000000,
		ST_DHI   = 12'b001000000000,
		ST_FIN   = 12'b010000000000,
		ST_OUT   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DEC;
			ST_DEC: begin
				if (sts.is_range) begin
					cmd.mul_a = 1'b1;
					state_d = ST_MULA2;
				end else begin
					cmd.simple = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_MULA2: begin
				cmd.mul_a_hi = 1'b1;
				state_d = ST_MULB;
			end
			ST_MULB: begin
				cmd.mul_b = 1'b1;
				state_d = ST_MULB2;
			end
			ST_MULB2: begin
				cmd.mul_b_hi = 1'b1;
				state_d = ST_DINI;
			end
			ST_DINI: begin
				if (sts.den_zero) begin
					cmd.finish_range = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.dist_mul = 1'b1;
				state_d = ST_DLO;
			end
			ST_DLO: begin
				cmd.dist_lo = 1'b1;
				state_d = ST_DHI;
			end
			ST_DHI: begin
				cmd.dist_hi = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish_range = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

@@ design/dstwr_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_dp
// Datapath: timestamp store, products, serial divider and result registers.
// ----------------------------------------------------------------------------
module dstwr_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   cfg_wdata,
	input  wire logic                               in_take,
	input  wire logic [1:0]                         cmd_in,
	input  wire logic [7:0]                         frame_type,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   event_time,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   remote_reply,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   remote_round,
	input  wire dstwr_pkg::dstwr_cmd_t             cmd,
	output dstwr_pkg::dstwr_sts_t                   sts,
	output logic [2:0]                              action,
	output logic [1:0]                              tx_type,
	output logic [dstwr_pkg::STAMP_BITS-1:0]        tx_time,
	output logic [dstwr_pkg::STAMP_BITS-1:0]        payload_reply,
	output logic [dstwr_pkg::STAMP_BITS-1:0]        payload_round,
	output logic signed [dstwr_pkg::TP_BITS-1:0]    tprop_ticks,
	output logic signed [dstwr_pkg::DIST_BITS-1:0]  distance_mm,
	output logic                                    range_valid
);
	localparam int SB = dstwr_pkg::STAMP_BITS;
	localparam int PB = dstwr_pkg::PROD_BITS;
	localparam int DB = dstwr_pkg::DEN_BITS;
	localparam int CB = dstwr_pkg::CNT_BITS;
	localparam int HB = SB / 2;
	localparam int UB = SB - HB;
	localparam logic [35:0] RCP = dstwr_pkg::DIST_RECIP;

	logic [SB-1:0] delay_q;
	logic [SB-1:0] rx_q [3];
	logic [SB-1:0] tx_q [4];
	logic [1:0]    last_q;
	logic [1:0]    c_q;
	logic [7:0]    ft_q;
	logic [SB-1:0] t_q, rr_q, rn_q;

	logic [SB-1:0]    ra, dbv;
	logic [SB+HB-1:0] pa_lo, pb_lo;
	logic [SB+UB-1:0] pa_hi, pb_hi;
	logic [PB-1:0]    pa_q, pb_q;
	logic [DB-1:0]    den_q;
	logic             neg_q;
	logic [PB-1:0]    quo_q;
	logic [DB:0]      rem_q;
	logic [CB-1:0]    cnt_q;
	logic [DB:0]      rtry;
	logic [DB:0]      dcmp;
	logic [SB:0]      mag;
	logic [44:0]      dx;
	logic [34:0]      dy_q;
	logic             dsat_q;
	logic [52:0]      dlo, dhi;
	logic [70:0]      dacc_q;
	logic [31:0]      dq;

	assign ra  = rx_q[1] - tx_q[0];
	assign dbv = tx_q[2] - rx_q[1];
	assign sts = '{
		is_range: (c_q == dstwr_pkg::CMD_RX_OK) && (ft_q == 8'd3),
		div_done: (cnt_q == CB'(1)),
		den_zero: (den_q == '0)
	};

	assign pa_lo = (SB+HB)'(ra) * (SB+HB)'(rn_q[HB-1:0]);
	assign pa_hi = (SB+UB)'(ra) * (SB+UB)'(rn_q[SB-1:HB]);
	assign pb_lo = (SB+HB)'(dbv) * (SB+HB)'(rr_q[HB-1:0]);
	assign pb_hi = (SB+UB)'(dbv) * (SB+UB)'(rr_q[SB-1:HB]);

	assign rtry = {rem_q[DB-1:0], quo_q[PB-1]};
	assign dcmp = {1'b0, den_q};

	always_comb begin
		if (quo_q[PB-1:SB+1] != '0) mag = neg_q ? {1'b1, {SB{1'b0}}} : {1'b0, {SB{1'b1}}};
		else if (neg_q && quo_q[SB:0] > {1'b1, {SB{1'b0}}}) mag = {1'b1, {SB{1'b0}}};
		else if (!neg_q && quo_q[SB]) mag = {1'b0, {SB{1'b1}}};
		else mag = quo_q[SB:0];
	end

	// distance = floor(floor(mag * 15625 / 1024) / 13)
	assign dx  = 45'(mag[30:0]) * 45'(dstwr_pkg::DIST_MUL);
	assign dlo = 53'(dy_q) * 53'(RCP[17:0]);
	assign dhi = 53'(dy_q) * 53'(RCP[35:18]);
	assign dq  = dacc_q[70:39];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= dstwr_pkg::ANSWER_DELAY_RST;
			for (int i = 0; i < 3; i++) rx_q[i] <= '0;
			for (int i = 0; i < 4; i++) tx_q[i] <= '0;
			last_q <= '0;
		end else begin
			if (cfg_we) delay_q <= cfg_wdata;
			if (cmd.simple) begin
				if (c_q == dstwr_pkg::CMD_START) last_q <= 2'd0;
				else if (c_q == dstwr_pkg::CMD_TX_DONE) tx_q[last_q] <= t_q;
				else if (c_q == dstwr_pkg::CMD_RX_OK && ft_q <= 8'd2) begin
					rx_q[ft_q[1:0]] <= t_q;
					last_q <= ft_q[1:0] + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			c_q <= cmd_in;
			ft_q <= frame_type;
			t_q <= event_time;
			rr_q <= remote_reply;
			rn_q <= remote_round;
		end
		if (cmd.mul_a) begin
			pa_q <= PB'(pa_lo);
			den_q <= DB'(ra) + DB'(rn_q) + DB'(rr_q) + DB'(dbv);
		end
		if (cmd.mul_a_hi) pa_q <= pa_q + (PB'(pa_hi) << HB);
		if (cmd.mul_b) pb_q <= PB'(pb_lo);
		if (cmd.mul_b_hi) pb_q <= pb_q + (PB'(pb_hi) << HB);
		if (cmd.div_init) begin
			neg_q <= pa_q < pb_q;
			quo_q <= (pa_q >= pb_q) ? pa_q - pb_q : pb_q - pa_q;
			rem_q <= '0;
			cnt_q <= CB'(PB);
		end
		if (cmd.div_step) begin
			if (rtry >= dcmp) begin
				rem_q <= rtry - dcmp;
				quo_q <= {quo_q[PB-2:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[PB-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CB'(1);
		end
		if (cmd.dist_mul) begin
			tprop_ticks <= neg_q ? -$signed(mag) : $signed(mag);
			dy_q <= dx[44:10];
			dsat_q <= (mag[SB:31] != '0);
		end
		if (cmd.dist_lo) dacc_q <= 71'(dlo);
		if (cmd.dist_hi) dacc_q <= dacc_q + (71'(dhi) << 18);
		if (cmd.simple) begin
			action <= dstwr_pkg::ACT_NONE;
			tx_type <= '0;
			tx_time <= '0;
			payload_reply <= '0;
			payload_round <= '0;
			tprop_ticks <= '0;
			distance_mm <= '0;
			range_valid <= 1'b0;
			unique case (c_q)
				dstwr_pkg::CMD_START: action <= dstwr_pkg::ACT_SEND_NOW;
				dstwr_pkg::CMD_RX_ERR: action <= dstwr_pkg::ACT_RX_RESET;
				dstwr_pkg::CMD_TX_DONE: action <= dstwr_pkg::ACT_RX_START;
				default: begin
					if (ft_q <= 8'd2) begin
						action <= dstwr_pkg::ACT_SEND_DLY;
						tx_type <= ft_q[1:0] + 2'd1;
						tx_time <= t_q + delay_q;
						if (ft_q == 8'd2) begin
							payload_reply <= tx_q[1] - rx_q[0];
							payload_round <= t_q - tx_q[1];
						end
					end
				end
			endcase
		end
		if (cmd.finish_range) begin
			action <= dstwr_pkg::ACT_RANGE;
			tx_type <= '0;
			tx_time <= '0;
			payload_reply <= '0;
			payload_round <= '0;
			if (den_q == '0) begin
				tprop_ticks <= '0;
				distance_mm <= '0;
				range_valid <= 1'b0;
			end else begin
				range_valid <= 1'b1;
				if (neg_q)
					distance_mm <= (dsat_q || dq > 32'h80000000) ? 32'sh80000000
						: -$signed(dq);
				else
					distance_mm <= (dsat_q || dq[31]) ? 32'sh7fffffff : $signed(dq);
			end
		end
	end
endmodule
`default_nettype wire

@@ design/ds_twr_ranging_engine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ds_twr_ranging_engine_core
// Double-sided two-way ranging engine over 40-bit radio timestamps.
// ----------------------------------------------------------------------------
// One radio event per input transaction (cmd, frame_type, event_time and the
// remote payload); exactly one result transaction follows for each event.
// answer_delay is written through cfg_we/cfg_wdata while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// After acceptance a non-ranging event is finished in the decode step. A
// received type 3 frame has two 80-bit products formed in two half-width
// steps each; with a zero denominator it ends there, else it goes on to an
// 80-step restoring divide of the numerator by the denominator, a scaling
// multiply and a two-step reciprocal multiply for the division by 13312.
// One event is handled at a time. in_stall is high from acceptance until the
// cycle after the result is taken. The result holds on the outputs while
// out_stall is high. Reset clears timestamps, last message number and
// restores the default answer delay.
// ----------------------------------------------------------------------------
module ds_twr_ranging_engine_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         cmd,
	input  wire logic [7:0]                         frame_type,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   event_time,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   remote_reply,
	input  wire logic [dstwr_pkg::STAMP_BITS-1:0]   remote_round,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [2:0]                              action,
	output logic [1:0]                              tx_type,
	output logic [dstwr_pkg::STAMP_BITS-1:0]        tx_time,
	output logic [dstwr_pkg::STAMP_BITS-1:0]        payload_reply,
	output logic [dstwr_pkg::STAMP_BITS-1:0]        payload_round,
	output logic signed [dstwr_pkg::TP_BITS-1:0]    tprop_ticks,
	output logic signed [dstwr_pkg::DIST_BITS-1:0]  distance_mm,
	output logic                                    range_valid
);
	dstwr_pkg::dstwr_cmd_t ctl;
	dstwr_pkg::dstwr_sts_t sts;

	dstwr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(ctl)
	);

	dstwr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_take(in_valid && !in_stall), .cmd_in(cmd), .frame_type(frame_type),
		.event_time(event_time), .remote_reply(remote_reply),
		.remote_round(remote_round), .cmd(ctl), .sts(sts), .action(action),
		.tx_type(tx_type), .tx_time(tx_time), .payload_reply(payload_reply),
		.payload_round(payload_round), .tprop_ticks(tprop_ticks),
		.distance_mm(distance_mm), .range_valid(range_valid)
	);
endmodule
`default_nettype wire

@@ design/dstwr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_checker
// Port-level checks of the ranging engine, bound to the top level.
// ----------------------------------------------------------------------------
module dstwr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] action,
	input wire logic       range_valid
);
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_valid_only_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_valid) |-> (action == dstwr_pkg::ACT_RANGE))
		else $error("range_valid outside range result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(action)))
		else $error("stalled result dropped");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("no busy after accept");
endmodule

bind ds_twr_ranging_engine_core dstwr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .action(action),
	.range_valid(range_valid)
);
`default_nettype wire
